// ===== rtl/core/md4_pkg.sv =====
// Shared types, constants and round helpers for the MD4 hash engine.
package md4_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] chain_t;

  localparam int unsigned BufDepth = 16;
  localparam int unsigned AddrW    = $clog2(BufDepth);
  localparam int unsigned RoundW   = 6;
  localparam int unsigned Rounds   = 48;

  localparam word_t K2 = 32'h5A82_7999;
  localparam word_t K3 = 32'h6ED9_EBA1;

  localparam chain_t InitChain = {32'h1032_5476, 32'h98ba_dcfe, 32'hefcd_ab89, 32'h6745_2301};

  // start pulse and chain reload from the control FSM
  typedef struct packed {
    logic start;
    logic reinit;
  } md4_cmp_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md4_cmp_sts_t;

  // buffer word used by round rnd
  function automatic logic [AddrW-1:0] msg_index(input logic [RoundW-1:0] rnd);
    logic [3:0] k;
    k = rnd[3:0];
    case (rnd[5:4])
      2'd0:    msg_index = k;
      2'd1:    msg_index = {k[1:0], k[3:2]};
      2'd2:    msg_index = {k[0], k[1], k[2], k[3]};
      default: msg_index = k;
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [RoundW-1:0] rnd);
    logic [1:0] j;
    j = rnd[1:0];
    rot_amount = 5'd3;
    case (rnd[5:4])
      2'd0: begin
        case (j)
          2'd0:    rot_amount = 5'd3;
          2'd1:    rot_amount = 5'd7;
          2'd2:    rot_amount = 5'd11;
          default: rot_amount = 5'd19;
        endcase
      end
      2'd1: begin
        case (j)
          2'd0:    rot_amount = 5'd3;
          2'd1:    rot_amount = 5'd5;
          2'd2:    rot_amount = 5'd9;
          default: rot_amount = 5'd13;
        endcase
      end
      default: begin
        case (j)
          2'd0:    rot_amount = 5'd3;
          2'd1:    rot_amount = 5'd9;
          2'd2:    rot_amount = 5'd11;
          default: rot_amount = 5'd15;
        endcase
      end
    endcase
  endfunction

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    rotl = dbl[63:32];
  endfunction

endpackage

// ===== rtl/core/md4_buf_ram.sv =====
// 16 x 32 message block buffer, one write port, one registered read port.
module md4_buf_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [md4_pkg::AddrW-1:0]  wr_addr,
  input  md4_pkg::word_t             wr_data,
  input  logic                       rd_en,
  input  logic [md4_pkg::AddrW-1:0]  rd_addr,
  output md4_pkg::word_t             rd_data
);
  import md4_pkg::*;

  word_t mem [BufDepth];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/md4_compress.sv =====
// MD4 compression: one round per cycle over the buffer memory, chain update at the end.
module md4_compress (
  input  logic                       clk,
  input  logic                       rst_n,
  input  md4_pkg::md4_cmp_ctl_t      ctl,
  output md4_pkg::md4_cmp_sts_t      sts,
  output logic                       rd_en,
  output logic [md4_pkg::AddrW-1:0]  rd_addr,
  input  md4_pkg::word_t             rd_data,
  output md4_pkg::chain_t            chain
);
  import md4_pkg::*;

  chain_t             chain_r;
  word_t              a_r, b_r, c_r, d_r;
  logic [RoundW-1:0]  rnd_r;
  logic               busy_r;
  logic               fin_r;

  word_t              fval;
  word_t              kval;
  word_t              new_w;
  logic [RoundW-1:0]  rnd_inc;

  assign rnd_inc = rnd_r + RoundW'(1);

  // next read address: word of round 0 on start, else the following round
  assign rd_en   = ctl.start || (busy_r && rnd_r != RoundW'(Rounds - 1));
  assign rd_addr = ctl.start ? msg_index('0) : msg_index(rnd_inc);

  always_comb begin
    case (rnd_r[5:4])
      2'd0: begin
        fval = (b_r & c_r) | (~b_r & d_r);
        kval = '0;
      end
      2'd1: begin
        fval = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        kval = K2;
      end
      default: begin
        fval = b_r ^ c_r ^ d_r;
        kval = K3;
      end
    endcase
    new_w = rotl(a_r + fval + rd_data + kval, rot_amount(rnd_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
      rnd_r   <= '0;
      chain_r <= InitChain;
    end else begin
      fin_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        a_r    <= chain_r[0];
        b_r    <= chain_r[1];
        c_r    <= chain_r[2];
        d_r    <= chain_r[3];
      end else if (busy_r) begin
        // rotate so the next updated register always sits in a_r
        a_r   <= d_r;
        b_r   <= new_w;
        c_r   <= b_r;
        d_r   <= c_r;
        rnd_r <= rnd_inc;
        if (rnd_r == RoundW'(Rounds - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
      if (ctl.reinit) begin
        chain_r <= InitChain;
      end
    end
  end

  assign sts.busy = busy_r || fin_r;
  assign sts.done = fin_r;
  assign chain    = chain_r;

endmodule

// ===== rtl/core/md4_hash_engine.sv =====
// MD4 hash engine top level: intake, padding control, digest output.
// Every 16th buffered word stalls intake for the compression, which runs its
// 48 rounds at one per cycle through the buffer memory read port.
// A last item adds 2 to 18 padding pushes and one or two compressions, then 4 digest items.
// Reset (rst_n low, synchronous) restores the MD4 initial chaining value, clears the
// byte total and fill count; buffer contents are left as they are.
module md4_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] message_word
  input  logic [2:0]  in_tuser,   // [2:0] byte_count
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] digest_index
  output logic        out_tlast
);
  import md4_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_OUT} state_t;

  state_t             state_r;
  logic [AddrW-1:0]   fill_r;
  logic [60:0]        total_r;
  logic               mark_r;   // 0x80 marker still to push as its own word
  logic               lo_r;     // low length word pushed
  logic               len_r;    // high length word pushed
  logic               pad_r;
  logic               start_r;
  logic [1:0]         idx_r;
  logic               out_tvalid_r;
  word_t              out_tdata_r;
  logic [1:0]         out_tuser_r;
  logic               out_tlast_r;

  md4_cmp_ctl_t       cmp_ctl;
  md4_cmp_sts_t       cmp_sts;
  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  word_t              rd_data;
  chain_t             chain;

  logic               acc;
  logic [2:0]         nbytes;
  word_t              last_w;
  word_t              pad_w;
  logic               push_en;
  word_t              push_w;
  logic               out_load;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign nbytes    = (in_tuser > 3'd4) ? 3'd4 : in_tuser;

  // last word: masked valid bytes with the marker right above them
  always_comb begin
    case (nbytes)
      3'd0:    last_w = 32'h0000_0080;
      3'd1:    last_w = {16'h0, 8'h80, in_tdata[7:0]};
      3'd2:    last_w = {8'h0, 8'h80, in_tdata[15:0]};
      3'd3:    last_w = {8'h80, in_tdata[23:0]};
      default: last_w = in_tdata;
    endcase
  end

  always_comb begin
    if (mark_r) begin
      pad_w = 32'h0000_0080;
    end else if (fill_r == AddrW'(14)) begin
      pad_w = {total_r[28:0], 3'b000};
    end else if (fill_r == AddrW'(15) && lo_r) begin
      pad_w = total_r[60:29];
    end else begin
      pad_w = '0;
    end
  end

  assign push_en  = acc || (state_r == S_PAD);
  assign push_w   = (state_r == S_PAD) ? pad_w : (in_tlast ? last_w : in_tdata);
  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  assign cmp_ctl.start  = start_r;
  assign cmp_ctl.reinit = out_load && (idx_r == 2'd3);

  md4_buf_ram u_buf (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (fill_r),
    .wr_data (push_w),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md4_compress u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cmp_ctl),
    .sts     (cmp_sts),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .chain   (chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      total_r      <= '0;
      mark_r       <= 1'b0;
      lo_r         <= 1'b0;
      len_r        <= 1'b0;
      pad_r        <= 1'b0;
      start_r      <= 1'b0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (acc) begin
        if (in_tlast) begin
          total_r <= total_r + 61'(nbytes);
          mark_r  <= (nbytes == 3'd4);
          lo_r    <= 1'b0;
          len_r   <= 1'b0;
          pad_r   <= 1'b1;
        end else begin
          total_r <= total_r + 61'd4;
        end
      end

      if (state_r == S_PAD) begin
        if (mark_r) begin
          mark_r <= 1'b0;
        end else if (fill_r == AddrW'(14)) begin
          lo_r <= 1'b1;
        end else if (fill_r == AddrW'(15) && lo_r) begin
          len_r <= 1'b1;
        end
      end

      if (push_en) begin
        if (fill_r == AddrW'(BufDepth - 1)) begin
          fill_r  <= '0;
          start_r <= 1'b1;
          state_r <= S_COMP;
        end else begin
          fill_r <= fill_r + AddrW'(1);
          if (acc && in_tlast) begin
            state_r <= S_PAD;
          end
        end
      end

      if (state_r == S_COMP && cmp_sts.done) begin
        if (len_r) begin
          state_r <= S_OUT;
          idx_r   <= '0;
        end else if (pad_r) begin
          state_r <= S_PAD;
        end else begin
          state_r <= S_IDLE;
        end
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= chain[idx_r];
        out_tuser_r  <= idx_r;
        out_tlast_r  <= (idx_r == 2'd3);
        idx_r        <= idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          state_r <= S_IDLE;
          total_r <= '0;
          fill_r  <= '0;
          pad_r   <= 1'b0;
          len_r   <= 1'b0;
          lo_r    <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_no_intake_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmp_sts.busy)
    else $error("intake open while compression runs");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> !cmp_sts.busy)
    else $error("buffer written during compression");

  a_start_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_ctl.start |-> (fill_r == '0) && (state_r == S_COMP) && !cmp_sts.busy)
    else $error("compression started without a full block");

  a_last_is_d: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == 2'd3))
    else $error("digest last flag on wrong word");

  a_len_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && cmp_sts.done && len_r) |=> (state_r == S_OUT))
    else $error("final block did not lead to digest output");

endmodule
